>>> rtl/apm_pkg.sv
// Shared types, codes and constants of the audio peak meter.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package apm_pkg;

    // level width default and fixed field widths
    localparam int LEVEL_BITS_DEF = 16;
    localparam int LEVEL_IN_BITS  = 18;
    localparam int OP_BITS        = 2;
    localparam int ZONE_BITS      = 2;
    localparam int THR_BITS       = 16;
    localparam int HOLD_BITS      = 8;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_PEAK = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RMS  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_TICK = 2'd2;

    // zone codes
    localparam logic [ZONE_BITS-1:0] ZONE_GOOD    = 2'd0;
    localparam logic [ZONE_BITS-1:0] ZONE_WARNING = 2'd1;
    localparam logic [ZONE_BITS-1:0] ZONE_DANGER  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_AUTO_DECAY = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_STEP = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TICKS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WARN_THR   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DANGER_THR = 3'd4;

    // register reset values
    localparam logic                 RST_AUTO_DECAY = 1'b1;
    localparam logic [THR_BITS-1:0]  RST_DECAY_STEP = 16'd983;
    localparam logic [HOLD_BITS-1:0] RST_HOLD_TICKS = 8'd20;
    localparam logic [THR_BITS-1:0]  RST_WARN_THR   = 16'd32845;
    localparam logic [THR_BITS-1:0]  RST_DANGER_THR = 16'd46395;

    // configuration seen by the datapath
    typedef struct packed {
        logic                 auto_decay_enable;
        logic [THR_BITS-1:0]  decay_step;
        logic [HOLD_BITS-1:0] hold_ticks;
        logic [THR_BITS-1:0]  warning_threshold;
        logic [THR_BITS-1:0]  danger_threshold;
    } apm_cfg_t;

    // one item handed to the level update
    typedef struct packed {
        logic               fire;
        logic [OP_BITS-1:0] operation;
    } apm_ctrl_t;

endpackage

>>> rtl/apm_in_if.sv
// Input request channel of the audio peak meter: operation and raw level.
// Depends on apm_pkg.
`timescale 1ns / 1ps

interface apm_in_if
    import apm_pkg::*;
();
    logic                            valid;
    logic                            ready;
    logic [OP_BITS-1:0]              operation;
    logic signed [LEVEL_IN_BITS-1:0] level;

    modport source (output valid, output operation, output level, input ready);
    modport sink   (input valid, input operation, input level, output ready);
endinterface

>>> rtl/apm_out_if.sv
// Result channel of the audio peak meter: levels, hold and zones.
// Depends on apm_pkg.
`timescale 1ns / 1ps

interface apm_out_if
    import apm_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] peak_level;
    logic [LEVEL_BITS-1:0] rms_level;
    logic [LEVEL_BITS-1:0] held_peak;
    logic [ZONE_BITS-1:0]  peak_zone;
    logic [ZONE_BITS-1:0]  rms_zone;

    modport source (output valid, output peak_level, output rms_level, output held_peak,
                    output peak_zone, output rms_zone, input ready);
    modport sink   (input valid, input peak_level, input rms_level, input held_peak,
                    input peak_zone, input rms_zone, output ready);
endinterface

>>> rtl/apm_cfg_if.sv
// Configuration write channel of the audio peak meter: index and data.
// Depends on apm_pkg.
`timescale 1ns / 1ps

interface apm_cfg_if
    import apm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/audio_peak_meter_with_hold.sv
// Audio level meter with peak hold: top level with input and result stages.
// Depends on apm_pkg, the apm_*_if interfaces, apm_cfg_regs, apm_level_update
// and apm_zone.
//
// Usage:
//   in_ch  carries requests: operation (peak sample, RMS sample, decay tick)
//          and a signed 18-bit level that is clamped to 0..full scale.
//   out_ch returns one result per request: peak, RMS and held peak levels
//          plus the peak and RMS zones (good, warning, danger).
//   cfg    writes the five setup registers by index; it is always ready.
//          Write it only while no request is in flight.
// An accepted request passes through the input register, then through the level
// update into the state registers, which are the result register. Throughput is
// one request per cycle while out_ch does not stall, with the shared
// peak/RMS/hold state updated once per request.
// When out_ch stalls, the result holds and the input register fills; in_ch
// ready drops only once both stages are occupied and resumes the cycle the
// result is taken. Reset clears all levels, the hold and its countdown, and
// loads the register defaults (decay on, step 983, hold 20 ticks, thresholds
// for -6 dB and -3 dB).
`timescale 1ns / 1ps

module audio_peak_meter_with_hold
    import apm_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    apm_in_if.sink     in_ch,
    apm_out_if.source  out_ch,
    apm_cfg_if.sink    cfg
);

    localparam int CLW = (LEVEL_BITS > LEVEL_IN_BITS) ? LEVEL_BITS : LEVEL_IN_BITS;

    apm_cfg_t              cfg_cur;
    apm_ctrl_t             ctrl;
    logic                  s1_valid_reg;
    logic [OP_BITS-1:0]    s1_op_reg;
    logic [LEVEL_BITS-1:0] s1_lvl_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  s1_advance;
    logic                  in_accept;
    logic [CLW-1:0]        mag_ext, full_ext;
    logic [LEVEL_BITS-1:0] lvl_clamped;

    // configuration registers
    apm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    // handshake: result stage frees when empty or taken
    assign s1_advance  = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || s1_advance;
    assign in_accept   = in_ch.valid && in_ch.ready;

    // clamp the raw level to 0..full scale
    always_comb
    begin
        mag_ext  = CLW'(in_ch.level[LEVEL_IN_BITS-2:0]);
        full_ext = CLW'({LEVEL_BITS{1'b1}});
        if (in_ch.level[LEVEL_IN_BITS-1])
        begin
            lvl_clamped = '0;
        end
        else if (mag_ext > full_ext)
        begin
            lvl_clamped = '1;
        end
        else
        begin
            lvl_clamped = LEVEL_BITS'(mag_ext);
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg  <= in_ch.operation;
            s1_lvl_reg <= lvl_clamped;
        end
    end

    // result valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // state update feeds the result registers
    assign ctrl.fire      = s1_valid_reg && s1_advance;
    assign ctrl.operation = s1_op_reg;

    apm_level_update #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .level      (s1_lvl_reg),
        .cfg        (cfg_cur),
        .peak_level (out_ch.peak_level),
        .rms_level  (out_ch.rms_level),
        .held_peak  (out_ch.held_peak)
    );

    // zones of the reported levels
    apm_zone #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_peak_zone (
        .level             (out_ch.peak_level),
        .warning_threshold (cfg_cur.warning_threshold),
        .danger_threshold  (cfg_cur.danger_threshold),
        .zone              (out_ch.peak_zone)
    );

    apm_zone #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_rms_zone (
        .level             (out_ch.rms_level),
        .warning_threshold (cfg_cur.warning_threshold),
        .danger_threshold  (cfg_cur.danger_threshold),
        .zone              (out_ch.rms_zone)
    );

    assign out_ch.valid = out_valid_reg;

endmodule

>>> rtl/apm_cfg_regs.sv
// Configuration register file of the audio peak meter.
// Depends on apm_pkg and apm_cfg_if.
`timescale 1ns / 1ps

module apm_cfg_regs
    import apm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    apm_cfg_if.sink     cfg,
    output apm_cfg_t    cfg_out
);

    apm_cfg_t cfg_reg;
    apm_cfg_t cfg_next;
    logic     wr_en;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    // decode a write request
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg.index)
                REG_AUTO_DECAY: cfg_next.auto_decay_enable = cfg.data[0];
                REG_DECAY_STEP: cfg_next.decay_step        = cfg.data[THR_BITS-1:0];
                REG_HOLD_TICKS: cfg_next.hold_ticks        = cfg.data[HOLD_BITS-1:0];
                REG_WARN_THR:   cfg_next.warning_threshold = cfg.data[THR_BITS-1:0];
                REG_DANGER_THR: cfg_next.danger_threshold  = cfg.data[THR_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_decay_enable <= RST_AUTO_DECAY;
            cfg_reg.decay_step        <= RST_DECAY_STEP;
            cfg_reg.hold_ticks        <= RST_HOLD_TICKS;
            cfg_reg.warning_threshold <= RST_WARN_THR;
            cfg_reg.danger_threshold  <= RST_DANGER_THR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_out = cfg_reg;

endmodule

>>> rtl/apm_level_update.sv
// Peak, RMS and hold state of the meter with the per-item update logic.
// Depends on apm_pkg.
`timescale 1ns / 1ps

module apm_level_update
    import apm_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  apm_ctrl_t             ctrl,
    input  logic [LEVEL_BITS-1:0] level,
    input  apm_cfg_t              cfg,
    output logic [LEVEL_BITS-1:0] peak_level,
    output logic [LEVEL_BITS-1:0] rms_level,
    output logic [LEVEL_BITS-1:0] held_peak
);

    localparam int CW = (LEVEL_BITS > THR_BITS) ? LEVEL_BITS : THR_BITS;

    logic [LEVEL_BITS-1:0] peak_reg,  peak_next;
    logic [LEVEL_BITS-1:0] rms_reg,   rms_next;
    logic [LEVEL_BITS-1:0] hold_reg,  hold_next;
    logic [HOLD_BITS-1:0]  count_reg, count_next;
    logic [CW-1:0]         peak_ext, rms_ext, step_ext;
    logic [LEVEL_BITS-1:0] peak_dec, rms_dec;

    // saturating decay by one step
    always_comb
    begin
        peak_ext = CW'(peak_reg);
        rms_ext  = CW'(rms_reg);
        step_ext = CW'(cfg.decay_step);
        peak_dec = (peak_ext > step_ext) ? LEVEL_BITS'(peak_ext - step_ext) : '0;
        rms_dec  = (rms_ext > step_ext) ? LEVEL_BITS'(rms_ext - step_ext) : '0;
    end

    // next state for one item
    always_comb
    begin
        peak_next  = peak_reg;
        rms_next   = rms_reg;
        hold_next  = hold_reg;
        count_next = count_reg;
        if (ctrl.fire)
        begin
            case (ctrl.operation)
                OP_PEAK:
                begin
                    peak_next = level;
                    if (level > hold_reg)
                    begin
                        hold_next  = level;
                        count_next = cfg.hold_ticks;
                    end
                end
                OP_RMS:
                begin
                    rms_next = level;
                end
                OP_TICK:
                begin
                    if (cfg.auto_decay_enable)
                    begin
                        peak_next = peak_dec;
                        rms_next  = rms_dec;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - HOLD_BITS'(1);
                            if (count_reg == HOLD_BITS'(1))
                            begin
                                hold_next = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    peak_next = peak_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            rms_reg   <= '0;
            hold_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            peak_reg  <= peak_next;
            rms_reg   <= rms_next;
            hold_reg  <= hold_next;
            count_reg <= count_next;
        end
    end

    assign peak_level = peak_reg;
    assign rms_level  = rms_reg;
    assign held_peak  = hold_reg;

endmodule

>>> rtl/apm_zone.sv
// Zone classifier: good, warning or danger against two thresholds.
// Depends on apm_pkg.
`timescale 1ns / 1ps

module apm_zone
    import apm_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)(
    input  logic [LEVEL_BITS-1:0] level,
    input  logic [THR_BITS-1:0]   warning_threshold,
    input  logic [THR_BITS-1:0]   danger_threshold,
    output logic [ZONE_BITS-1:0]  zone
);

    localparam int CW = (LEVEL_BITS > THR_BITS) ? LEVEL_BITS : THR_BITS;

    logic [CW-1:0] lvl_ext, warn_ext, danger_ext;

    // danger test takes priority
    always_comb
    begin
        lvl_ext    = CW'(level);
        warn_ext   = CW'(warning_threshold);
        danger_ext = CW'(danger_threshold);
        if (lvl_ext >= danger_ext)
        begin
            zone = ZONE_DANGER;
        end
        else if (lvl_ext >= warn_ext)
        begin
            zone = ZONE_WARNING;
        end
        else
        begin
            zone = ZONE_GOOD;
        end
    end

endmodule

>>> rtl/apm_checker.sv
// Port-level checks of the audio peak meter, bound to the top level.
// Depends on apm_pkg and the apm_*_if interfaces.
`timescale 1ns / 1ps

module apm_checker
    import apm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    apm_in_if.sink     in_ch,
    apm_out_if.source  out_ch,
    apm_cfg_if.sink    cfg
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign out_stall = out_ch.valid && !out_ch.ready;

    // a stalled result keeps its levels
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> out_ch.valid && $stable(out_ch.peak_level)
                      && $stable(out_ch.rms_level) && $stable(out_ch.held_peak))
        else $error("stalled result changed");

    // a ready receiver never blocks new requests
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.ready |-> in_ch.ready)
        else $error("input blocked while output ready");

    // a fresh result is preceded by an accepted request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(in_acc, 2))
        else $error("result without request");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |-> cfg.ready)
        else $error("configuration write refused");

endmodule

bind audio_peak_meter_with_hold apm_checker u_apm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
);

>>> sim/apm_meter_checker.sv
// Checker for the audio peak meter: watches request, result and setup channels,
// predicts every result and compares it field by field.
// Depends on apm_pkg and the apm_in_if, apm_out_if and apm_cfg_if interfaces.
`timescale 1ns / 1ps

module apm_meter_checker
    import apm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    apm_in_if    in_mon,
    apm_out_if   out_mon,
    apm_cfg_if   cfg_mon,
    output int   fail_count,
    output int   pending,
    output int   compared
);

    typedef logic [LEVEL_BITS_DEF-1:0] level_t;

    typedef struct packed {
        level_t               peak_level;
        level_t               rms_level;
        level_t               held_peak;
        logic [ZONE_BITS-1:0] peak_zone;
        logic [ZONE_BITS-1:0] rms_zone;
    } meter_reading_t;

    // predicted readings in request order
    meter_reading_t readings_due[$];

    // shadow of the setup registers and the meter state
    apm_cfg_t             meter_cfg;
    level_t               peak_now;
    level_t               rms_now;
    level_t               hold_now;
    logic [HOLD_BITS-1:0] hold_left;

    int             errors;
    int             results_seen;
    meter_reading_t got_reading;
    meter_reading_t want_reading;

    assign fail_count = errors;
    assign compared   = results_seen;

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        errors++;
    endtask

    // clamp the signed sample to 0..full scale
    function automatic level_t clamp_sample(logic signed [LEVEL_IN_BITS-1:0] raw);
        if (raw < 0)
            return '0;
        if (raw > $signed({2'b00, {LEVEL_BITS_DEF{1'b1}}}))
            return '1;
        return raw[LEVEL_BITS_DEF-1:0];
    endfunction

    // danger is tested first, plain unsigned compares
    function automatic logic [ZONE_BITS-1:0] zone_for(level_t lvl);
        if (lvl >= meter_cfg.danger_threshold)
            return ZONE_DANGER;
        if (lvl >= meter_cfg.warning_threshold)
            return ZONE_WARNING;
        return ZONE_GOOD;
    endfunction

    // apply one request to the shadow meter and return the reading it yields
    function automatic meter_reading_t step_meter(logic [OP_BITS-1:0] op,
                                                  logic signed [LEVEL_IN_BITS-1:0] raw);
        level_t         sample;
        meter_reading_t reading;
        sample = clamp_sample(raw);
        case (op)
            OP_PEAK:
            begin
                peak_now = sample;
                // equal to the hold does not recapture
                if (peak_now > hold_now)
                begin
                    hold_now  = peak_now;
                    hold_left = meter_cfg.hold_ticks;
                end
            end
            OP_RMS:
            begin
                rms_now = sample;
            end
            OP_TICK:
            begin
                if (meter_cfg.auto_decay_enable)
                begin
                    peak_now = (peak_now > meter_cfg.decay_step) ?
                               peak_now - meter_cfg.decay_step : '0;
                    rms_now  = (rms_now > meter_cfg.decay_step) ?
                               rms_now - meter_cfg.decay_step : '0;
                    // a zero countdown never clears its hold
                    if (hold_left != 0)
                    begin
                        hold_left = hold_left - HOLD_BITS'(1);
                        if (hold_left == 0)
                            hold_now = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        reading.peak_level = peak_now;
        reading.rms_level  = rms_now;
        reading.held_peak  = hold_now;
        reading.peak_zone  = zone_for(peak_now);
        reading.rms_zone   = zone_for(rms_now);
        return reading;
    endfunction

    // setup write; indexes past the list are ignored
    task automatic apply_reg_write(logic [CFG_IDX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_AUTO_DECAY: meter_cfg.auto_decay_enable = value[0];
            REG_DECAY_STEP: meter_cfg.decay_step        = value;
            REG_HOLD_TICKS: meter_cfg.hold_ticks        = value[HOLD_BITS-1:0];
            REG_WARN_THR:   meter_cfg.warning_threshold = value;
            REG_DANGER_THR: meter_cfg.danger_threshold  = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic check_reading(meter_reading_t got, meter_reading_t want);
        if (got.peak_level !== want.peak_level)
            report_mismatch($sformatf("peak_level %0d, predicted %0d",
                                      got.peak_level, want.peak_level));
        if (got.rms_level !== want.rms_level)
            report_mismatch($sformatf("rms_level %0d, predicted %0d",
                                      got.rms_level, want.rms_level));
        if (got.held_peak !== want.held_peak)
            report_mismatch($sformatf("held_peak %0d, predicted %0d",
                                      got.held_peak, want.held_peak));
        if (got.peak_zone !== want.peak_zone)
            report_mismatch($sformatf("peak_zone %0d, predicted %0d",
                                      got.peak_zone, want.peak_zone));
        if (got.rms_zone !== want.rms_zone)
            report_mismatch($sformatf("rms_zone %0d, predicted %0d",
                                      got.rms_zone, want.rms_zone));
    endtask

    // results are checked before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meter_cfg.auto_decay_enable = RST_AUTO_DECAY;
            meter_cfg.decay_step        = RST_DECAY_STEP;
            meter_cfg.hold_ticks        = RST_HOLD_TICKS;
            meter_cfg.warning_threshold = RST_WARN_THR;
            meter_cfg.danger_threshold  = RST_DANGER_THR;
            peak_now  = '0;
            rms_now   = '0;
            hold_now  = '0;
            hold_left = '0;
            readings_due.delete();
            errors       = 0;
            results_seen = 0;
            pending     <= 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got_reading.peak_level = out_mon.peak_level;
                got_reading.rms_level  = out_mon.rms_level;
                got_reading.held_peak  = out_mon.held_peak;
                got_reading.peak_zone  = out_mon.peak_zone;
                got_reading.rms_zone   = out_mon.rms_zone;
                if (readings_due.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want_reading = readings_due.pop_front();
                    check_reading(got_reading, want_reading);
                    results_seen++;
                end
            end
            if (cfg_mon.valid && cfg_mon.ready)
                apply_reg_write(cfg_mon.index, cfg_mon.data);
            if (in_mon.valid && in_mon.ready)
                readings_due.push_back(step_meter(in_mon.operation, in_mon.level));
            pending <= readings_due.size();
        end
    end

endmodule

>>> sim/testbench.sv
// Top of the audio peak meter testbench: clock, reset, request and setup stimulus,
// result back-pressure and the verdict.
// Depends on apm_pkg, the apm_*_if interfaces, apm_meter_checker and the meter.
`timescale 1ns / 1ps

module testbench;
    import apm_pkg::*;

    localparam int PHASES           = 10;
    localparam int PHASE_REQUESTS   = 110;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES    = 4;

    // codes the package leaves unnamed
    localparam logic [OP_BITS-1:0]      OP_SPARE  = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = REG_DANGER_THR + 3'd1;

    logic clk;
    logic rst_n;

    apm_in_if                                 in_ch();
    apm_out_if #(.LEVEL_BITS(LEVEL_BITS_DEF)) out_ch();
    apm_cfg_if                                cfg_ch();

    int fail_count;
    int pending;
    int compared;
    int sent;
    int burst_left;
    int long_holds;
    bit long_hold_req;

    logic [THR_BITS-1:0] warn_now;
    logic [THR_BITS-1:0] danger_now;

    audio_peak_meter_with_hold #(.LEVEL_BITS(LEVEL_BITS_DEF)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg_ch.sink)
    );

    apm_meter_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .cfg_mon    (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .compared   (compared)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("[audio_peak_meter_with_hold] ERROR");
        $finish;
    end

    // result back-pressure: free runs, random stalls and requested long holds
    initial
    begin
        int mode;
        out_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_holds++;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                repeat ($urandom_range(4, 40))
                begin
                    case (mode)
                        0:       out_ch.ready <= 1'b1;
                        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                        default: out_ch.ready <= $urandom_range(0, 1);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // one request, sent in bursts with random gaps between them
    task automatic send_request(logic [OP_BITS-1:0] op, logic [LEVEL_IN_BITS-1:0] lvl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.level     <= lvl;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent++;
    endtask

    // stop sending and wait until every result is back
    task automatic drain_meter();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // register setting of each phase: reset values, then extremes and directed cases, then random ones
    task automatic program_setting(int phase);
        logic [CFG_DATA_BITS-1:0] auto_val;
        logic [CFG_DATA_BITS-1:0] step_val;
        logic [CFG_DATA_BITS-1:0] hold_val;
        auto_val   = 16'd1;
        step_val   = RST_DECAY_STEP;
        hold_val   = RST_HOLD_TICKS;
        warn_now   = RST_WARN_THR;
        danger_now = RST_DANGER_THR;
        case (phase)
            0:
            begin
            end
            1:
            begin
                // zero step, zero hold countdown, zero thresholds
                step_val   = 16'd0;
                hold_val   = 16'd0;
                warn_now   = 16'd0;
                danger_now = 16'd0;
            end
            2:
            begin
                step_val   = 16'hFFFF;
                hold_val   = 16'd255;
                warn_now   = 16'hFFFF;
                danger_now = 16'hFFFF;
            end
            3:
            begin
                // decay off: ticks change nothing
                auto_val = 16'hFFFE;
                step_val = 16'($urandom_range(1, 4000));
                hold_val = 16'd1;
            end
            4:
            begin
                // thresholds out of order
                step_val   = 16'd1;
                hold_val   = 16'd1;
                warn_now   = 16'd50000;
                danger_now = 16'd20000;
            end
            default:
            begin
                auto_val   = 16'($urandom_range(0, 16'hFFFF)) & 16'hFFFE;
                auto_val[0] = ($urandom_range(0, 3) != 0);
                step_val   = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                             16'($urandom_range(0, 3000));
                hold_val   = {8'($urandom), 8'($urandom_range(0, 12))};
                warn_now   = 16'($urandom);
                danger_now = 16'($urandom);
            end
        endcase
        write_reg(REG_AUTO_DECAY, auto_val);
        write_reg(REG_DECAY_STEP, step_val);
        write_reg(REG_HOLD_TICKS, hold_val);
        write_reg(REG_WARN_THR, warn_now);
        write_reg(REG_DANGER_THR, danger_now);
        // writes past the register list must leave the setting alone
        if (phase == 4)
        begin
            write_reg(REG_SPARE, 16'($urandom));
            write_reg(REG_SPARE + 3'd1, 16'($urandom));
            write_reg(REG_SPARE + 3'd2, 16'($urandom));
        end
    endtask

    function automatic logic [OP_BITS-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return OP_PEAK;
        if (r < 60)
            return OP_RMS;
        if (r < 95)
            return OP_TICK;
        return OP_SPARE;
    endfunction

    // mostly in-range levels, some raw 18-bit values, extremes and threshold edges
    function automatic logic [LEVEL_IN_BITS-1:0] pick_level();
        logic [LEVEL_IN_BITS-1:0] edges[6];
        edges = '{18'h20000, 18'h3FFFF, 18'h00000, 18'h0FFFF, 18'h10000, 18'h1FFFF};
        case ($urandom_range(0, 9))
            0:       return LEVEL_IN_BITS'($urandom);
            1:       return edges[$urandom_range(0, 5)];
            2:       return {2'b00, warn_now} + LEVEL_IN_BITS'($urandom_range(0, 4)) - 18'd2;
            3:       return {2'b00, danger_now} + LEVEL_IN_BITS'($urandom_range(0, 4)) - 18'd2;
            default: return LEVEL_IN_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // stimulus
    initial
    begin
        int phase;
        int done_in_phase;
        int run;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_PEAK;
        in_ch.level     = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_AUTO_DECAY;
        cfg_ch.data     = '0;
        rst_n           = 1'b0;
        sent            = 0;
        burst_left      = 0;
        long_holds      = 0;
        long_hold_req   = 1'b0;
        warn_now        = RST_WARN_THR;
        danger_now      = RST_DANGER_THR;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests under the reset setting
        send_request(OP_PEAK, 18'h1FFFF);   // clamps to full scale, captures hold
        send_request(OP_PEAK, 18'h0FFFF);   // equal to the hold: no recapture
        send_request(OP_PEAK, 18'h20000);   // most negative clamps to zero
        send_request(OP_RMS, 18'h10000);    // just over full scale
        send_request(OP_RMS, 18'h3FFFF);    // minus one clamps to zero
        send_request(OP_RMS, {2'b00, RST_DANGER_THR});
        send_request(OP_RMS, {2'b00, RST_DANGER_THR} - 18'd1);
        send_request(OP_PEAK, {2'b00, RST_WARN_THR});
        send_request(OP_PEAK, {2'b00, RST_WARN_THR} - 18'd1);
        send_request(OP_TICK, 18'h2AAAA);
        send_request(OP_SPARE, 18'h15555);  // unused code reports state only
        send_request(OP_SPARE, 18'h2AAAA);
        send_request(OP_RMS, 18'h0FFFF);
        send_request(OP_TICK, 18'h15555);
        send_request(OP_PEAK, 18'h00000);
        send_request(OP_TICK, 18'h3FFFF);

        // random phases, each under its own register setting
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_meter();
            program_setting(phase);
            if (phase == 1 || phase == 6)
                long_hold_req = 1'b1;
            done_in_phase = 0;
            while (done_in_phase < PHASE_REQUESTS)
            begin
                // runs of ticks let levels decay out and holds expire
                if ($urandom_range(0, 11) == 0)
                begin
                    run = $urandom_range(3, 25);
                    repeat (run) send_request(OP_TICK, LEVEL_IN_BITS'($urandom));
                    done_in_phase += run;
                end
                else
                begin
                    send_request(pick_op(), pick_level());
                    done_in_phase++;
                end
            end
        end
        drain_meter();

        $display("sent %0d requests under %0d register settings, %0d results compared",
                 sent, PHASES + 1, compared);
        $display("result side held off %0d times for %0d cycles with requests waiting",
                 long_holds, LONG_HOLD_CYCLES);
        if (fail_count == 0)
            $display("[audio_peak_meter_with_hold] OK");
        else
            $display("[audio_peak_meter_with_hold] ERROR");
        $finish;
    end

endmodule

>>> audio_peak_meter_with_hold.f
rtl/apm_pkg.sv
rtl/apm_in_if.sv
rtl/apm_out_if.sv
rtl/apm_cfg_if.sv
rtl/apm_cfg_regs.sv
rtl/apm_level_update.sv
rtl/apm_zone.sv
rtl/audio_peak_meter_with_hold.sv
rtl/apm_checker.sv
sim/apm_meter_checker.sv
sim/testbench.sv
